>>> design/sbms_pkg.sv
// Package for the sparse bit matrix store: word types, operation and status codes,
// controller states and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package sbms_pkg;

  localparam int unsigned ROWS_W  = 14;
  localparam int unsigned BYTE_W  = 13;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PATCH_W = 16;

  localparam logic [CNT_W-1:0] NONE_PATCH = '1;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_ADD   = 2'd1,
    OP_END   = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_BUILT   = 3'd1,
    STS_INVALID = 3'd2,
    STS_ORDER   = 3'd3,
    STS_FULL    = 3'd4,
    STS_RANGE   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COLRD,
    S_SEARCH,
    S_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [PATCH_W-1:0] source;
    logic [PATCH_W-1:0] target;
  } in_word_t;

  typedef struct packed {
    logic             visible;
    logic [CNT_W-1:0] pair_count;
    status_e          status;
  } out_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_off;
    logic [7:0]        bits;
  } entry_t;

endpackage

>>> design/sbms_col_store.sv
// Column table memory of the sparse bit matrix store: one write and one registered read
// port, with a clearing sweep after reset. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module sbms_col_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 30
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  output logic          busy_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] sweep_q;
  logic          busy_q;
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      busy_q  <= 1'b1;
    end else if (busy_q) begin
      sweep_q <= sweep_q + AW'(1);
      if (sweep_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[sweep_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

>>> design/sparse_bit_matrix_store_unit.sv
// Top level of the sparse bit matrix store: build controller, row memory and search.
// Depends on sbms_pkg and sbms_col_store.
`timescale 1ns / 1ps
//
//  port group   direction  handshake               payload
//  in           input      in_valid_i / in_stall_o    in_word_i  (op, source, target)
//  out          output     out_valid_o / out_stall_i  out_word_o (visible, pair_count, status)
//  cfg          input      cfg_we_i                   cfg_wdata_i (patches in use)
//
//  One word is worked on at a time. Add, end and any word that reads no column go from
//  S_EXEC straight to S_RESP, where the result loads into the output register; a begin
//  that reads its column passes S_EXEC, S_COLRD and S_RESP, and a query that reaches its
//  column passes S_EXEC, S_COLRD, S_SEARCH, S_CMP once per row read in its binary search
//  (at most 14) and S_RESP. After reset the column table is swept to zero with in_stall_o
//  high. A new word is accepted while a result still waits in the output register; the
//  controller holds in S_RESP only while that older result is still stalled.

module sparse_bit_matrix_store_unit #(
  parameter int unsigned MAX_PATCHES = 65536,
  parameter int unsigned ENTRY_DEPTH = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [16:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sbms_pkg::in_word_t     in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sbms_pkg::out_word_t    out_word_o
);

  import sbms_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_PATCHES);
  localparam int unsigned EW  = $clog2(ENTRY_DEPTH);
  localparam int unsigned IW  = ((EW > ROWS_W) ? EW : ROWS_W) + 1;
  localparam int unsigned CDW = ROWS_W + EW;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  num_q;
  in_word_t          item_q, item_d;
  out_word_t         res_q, res_d;
  out_word_t         out_q;
  logic              out_valid_q;

  logic              building_q, building_d;
  logic [PATCH_W-1:0] open_q, open_d;
  logic [EW-1:0]     start_q, start_d;
  logic [ROWS_W-1:0] rows_q, rows_d;
  logic [EW:0]       free_q, free_d;
  logic [CNT_W-1:0]  prev_q, prev_d;
  logic [7:0]        pending_q, pending_d;
  logic [CNT_W-1:0]  tally_q, tally_d;

  logic [PATCH_W-1:0] y_q, y_d;
  logic [EW-1:0]     qstart_q, qstart_d;
  logic [ROWS_W-1:0] lo_q, lo_d;
  logic [ROWS_W-1:0] hi_q, hi_d;
  logic [ROWS_W-1:0] mid_q, mid_d;

  logic              col_we, col_re, col_busy;
  logic [CW-1:0]     col_waddr, col_raddr;
  logic [CDW-1:0]    col_wdata, col_rdata;
  logic [ROWS_W-1:0] col_rows;
  logic [EW-1:0]     col_start;

  entry_t            ent_mem [ENTRY_DEPTH];
  entry_t            ent_rd_q;
  entry_t            ent_wdata;
  logic              ent_we, ent_re;
  logic [EW-1:0]     ent_waddr, ent_raddr;

  logic [PATCH_W-1:0] src, tgt, q_small, q_large;
  logic              src_ok, tgt_ok, large_ok;
  logic              prev_none, add_dup, add_down, add_new, ent_full, add_do;
  status_e           add_status;
  logic [7:0]        add_bit;
  logic              accept, out_free, hit;
  logic [ROWS_W-1:0] lo_n, hi_n, pr_lo, pr_hi, pr_mid;
  logic [IW-1:0]     pr_idx;
  logic              probe_go;

  function automatic logic patch_ok(input logic [PATCH_W-1:0] p,
                                    input logic [CNT_W-1:0] limit);
    return ({1'b0, p} < limit) && (32'(p) < MAX_PATCHES);
  endfunction

  sbms_col_store #(
    .DEPTH (MAX_PATCHES),
    .AW    (CW),
    .DW    (CDW)
  ) u_col_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .re_i    (col_re),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata),
    .busy_o  (col_busy)
  );

  assign col_rows  = col_rdata[CDW-1:EW];
  assign col_start = col_rdata[EW-1:0];

  assign in_stall_o  = (state_q != S_IDLE) || col_busy;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign src      = item_q.source;
  assign tgt      = item_q.target;
  assign q_small  = (src < tgt) ? src : tgt;
  assign q_large  = (src < tgt) ? tgt : src;
  assign src_ok   = patch_ok(src, num_q);
  assign tgt_ok   = patch_ok(tgt, num_q);
  assign large_ok = patch_ok(q_large, num_q);

  assign prev_none = (prev_q == NONE_PATCH);
  assign add_dup   = !prev_none && ({1'b0, tgt} == prev_q);
  assign add_down  = !prev_none && ({1'b0, tgt} < prev_q);
  assign add_new   = prev_none || (tgt[PATCH_W-1:3] != prev_q[PATCH_W-1:3]);
  assign ent_full  = (free_q >= (EW + 1)'(ENTRY_DEPTH));
  assign add_bit   = 8'(1) << tgt[2:0];

  always_comb begin
    add_do = 1'b0;
    if (!building_q) begin
      add_status = STS_ORDER;
    end else if (!tgt_ok || (tgt < open_q)) begin
      add_status = STS_INVALID;
    end else if (add_dup) begin
      add_status = STS_OK;
    end else if (add_down) begin
      add_status = STS_ORDER;
    end else if (add_new && ent_full) begin
      add_status = STS_FULL;
    end else begin
      add_status = STS_OK;
      add_do     = 1'b1;
    end
  end

  // Binary search probe: the next bounds come from the row just read in S_CMP.
  assign hit  = (state_q == S_CMP) && (ent_rd_q.byte_off == y_q[PATCH_W-1:3]);
  assign lo_n = (ent_rd_q.byte_off < y_q[PATCH_W-1:3]) ? mid_q + ROWS_W'(1) : lo_q;
  assign hi_n = (ent_rd_q.byte_off < y_q[PATCH_W-1:3]) ? hi_q : mid_q;
  assign pr_lo    = (state_q == S_CMP) ? lo_n : lo_q;
  assign pr_hi    = (state_q == S_CMP) ? hi_n : hi_q;
  assign pr_mid   = pr_lo + ((pr_hi - pr_lo) >> 1);
  assign pr_idx   = IW'(qstart_q) + IW'(pr_mid);
  assign probe_go = (pr_lo < pr_hi) && (pr_idx < IW'(ENTRY_DEPTH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_q.op)
          OP_BEGIN: state_d = (!building_q && src_ok) ? S_COLRD : S_RESP;
          OP_QUERY: state_d = ((src != tgt) && large_ok) ? S_COLRD : S_RESP;
          default:  state_d = S_RESP;
        endcase
      end
      S_COLRD: begin
        state_d = (item_q.op == OP_QUERY) ? S_SEARCH : S_RESP;
      end
      S_SEARCH: begin
        state_d = probe_go ? S_CMP : S_RESP;
      end
      S_CMP: begin
        state_d = (!hit && probe_go) ? S_CMP : S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    item_d     = item_q;
    res_d      = res_q;
    building_d = building_q;
    open_d     = open_q;
    start_d    = start_q;
    rows_d     = rows_q;
    free_d     = free_q;
    prev_d     = prev_q;
    pending_d  = pending_q;
    tally_d    = tally_q;
    y_d        = y_q;
    qstart_d   = qstart_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    col_we     = 1'b0;
    col_waddr  = CW'(open_q);
    col_wdata  = {rows_q + ROWS_W'(1), start_q};
    col_re     = 1'b0;
    col_raddr  = CW'(src);
    ent_we     = 1'b0;
    ent_waddr  = free_q[EW-1:0];
    ent_wdata  = '{byte_off: tgt[PATCH_W-1:3], bits: add_bit};
    ent_re     = 1'b0;
    ent_raddr  = pr_idx[EW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = in_word_i;
        end
      end
      S_EXEC: begin
        res_d = '{visible: 1'b0, pair_count: '0, status: STS_OK};
        case (item_q.op)
          OP_BEGIN: begin
            if (building_q) begin
              res_d.status = STS_ORDER;
            end else if (!src_ok) begin
              res_d.status = STS_INVALID;
            end else begin
              col_re = 1'b1;
            end
          end
          OP_ADD: begin
            res_d.status = add_status;
            if (add_do) begin
              prev_d  = {1'b0, tgt};
              tally_d = tally_q + CNT_W'(1);
              ent_we  = 1'b1;
              if (add_new) begin
                pending_d = add_bit;
                free_d    = free_q + (EW + 1)'(1);
                rows_d    = rows_q + ROWS_W'(1);
                col_we    = 1'b1;
              end else begin
                pending_d      = pending_q | add_bit;
                ent_waddr      = EW'(free_q - (EW + 1)'(1));
                ent_wdata.bits = pending_q | add_bit;
              end
            end
          end
          OP_END: begin
            if (building_q) begin
              res_d.pair_count = tally_q;
              building_d       = 1'b0;
              prev_d           = NONE_PATCH;
              pending_d        = '0;
              tally_d          = '0;
            end else begin
              res_d.status = STS_ORDER;
            end
          end
          OP_QUERY: begin
            y_d = q_large;
            if (src == tgt) begin
              res_d.visible = 1'b1;
            end else if (!large_ok) begin
              res_d.status = STS_RANGE;
            end else begin
              col_re    = 1'b1;
              col_raddr = CW'(q_small);
            end
          end
          default: res_d.status = STS_ORDER;
        endcase
      end
      S_COLRD: begin
        if (item_q.op == OP_QUERY) begin
          lo_d     = '0;
          hi_d     = col_rows;
          qstart_d = col_start;
        end else if (col_rows != '0) begin
          res_d.status = STS_BUILT;
        end else begin
          building_d = 1'b1;
          open_d     = src;
          start_d    = free_q[EW-1:0];
          rows_d     = '0;
          prev_d     = NONE_PATCH;
          pending_d  = '0;
          tally_d    = '0;
        end
      end
      S_SEARCH, S_CMP: begin
        if (hit) begin
          res_d.visible = ent_rd_q.bits[y_q[2:0]];
        end else if (probe_go) begin
          ent_re = 1'b1;
          lo_d   = pr_lo;
          hi_d   = pr_hi;
          mid_d  = pr_mid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_q       <= '0;
      out_valid_q <= 1'b0;
      building_q  <= 1'b0;
      open_q      <= '0;
      free_q      <= '0;
      prev_q      <= NONE_PATCH;
      pending_q   <= '0;
      tally_q     <= '0;
      rows_q      <= '0;
    end else begin
      state_q    <= state_d;
      building_q <= building_d;
      open_q     <= open_d;
      free_q     <= free_d;
      prev_q     <= prev_d;
      pending_q  <= pending_d;
      tally_q    <= tally_d;
      rows_q     <= rows_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    start_q  <= start_d;
    y_q      <= y_d;
    qstart_q <= qstart_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    if ((state_q == S_RESP) && out_free) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

endmodule

>>> design/sbms_checker.sv
// Port-level checks for the sparse bit matrix store, bound to its top level.
// Depends on sbms_pkg and sparse_bit_matrix_store_unit.
`timescale 1ns / 1ps

module sbms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sbms_pkg::out_word_t out_word_o
);

  import sbms_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the previous word finished");

  a_count_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.pair_count != '0) |->
      (out_word_o.status == STS_OK) && !out_word_o.visible)
    else $error("pair count on a word that is not a good end");

  a_visible_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.visible |->
      (out_word_o.status == STS_OK) && (out_word_o.pair_count == '0))
    else $error("visible bit set on a failed or non-query word");

endmodule

bind sparse_bit_matrix_store_unit sbms_checker u_sbms_checker (.*);
